// ===== sv/hlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hlcd_pkg: shared types and constants for the header/length/checksum deframer
// Result kinds, queue entry layout, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package hlcd_pkg;

	// Result kind codes
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	// Configuration register indexes (paddr[2])
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	// Register reset values
	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	// Frame position codes before the body
	localparam logic [7:0] POS_HUNT  = 8'd0;
	localparam logic [7:0] POS_SYNC2 = 8'd1;
	localparam logic [7:0] POS_LEN   = 8'd2;
	localparam logic [7:0] POS_BODY  = 8'd3;

	// Default depth of the queue between front and back
	localparam int FIFO_DEPTH_DEF = 4;

	// Classified event passed from front to back
	typedef struct packed {
		logic       is_end;  // end of frame: data holds the received checksum
		logic [7:0] data;
		logic [7:0] csum;    // running sum at the checksum byte
		logic [7:0] pos;
		logic [7:0] len;
	} hlcd_entry_t;

	// Queue status seen by front, back and top
	typedef struct packed {
		logic full;
		logic empty;
	} hlcd_fifo_status_t;

endpackage

`default_nettype wire

// ===== sv/hlcd_front.sv =====
// ----------------------------------------------------------------------------
// hlcd_front: frame tracker
// Accepts received bytes, follows the header/length/body position and pushes
// payload and end-of-frame events into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcd_front
	import hlcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rx_byte,
	input  wire logic [7:0]        sync_first,
	input  wire logic [7:0]        sync_second,
	input  wire hlcd_fifo_status_t fifo_status,
	output logic                   push,
	output hlcd_entry_t            push_entry
);

	logic [7:0] position_q;
	logic [7:0] length_q;
	logic [7:0] sum_q;
	logic       accept;
	logic       is_payload;
	logic [7:0] position_d;
	logic [7:0] length_d;
	logic [7:0] sum_d;

	// Transfer happens whenever a byte is valid and the queue has room
	assign in_stall = fifo_status.full;
	assign accept   = in_valid & ~fifo_status.full;

	// Payload while position + 1 < L (a zero length gives none)
	assign is_payload = ({1'b0, position_q} + 9'd1) < {1'b0, length_q};

	// Next position, length and sum
	always_comb begin
		position_d = position_q;
		length_d   = length_q;
		sum_d      = sum_q;
		push       = 1'b0;
		push_entry = '{is_end: 1'b0, data: rx_byte, csum: sum_q,
			pos: position_q, len: length_q};
		case (position_q)
			POS_HUNT: begin
				if (rx_byte == sync_first) begin
					position_d = POS_SYNC2;
				end
			end
			POS_SYNC2: begin
				position_d = (rx_byte == sync_second) ? POS_LEN : POS_HUNT;
			end
			POS_LEN: begin
				length_d   = rx_byte;
				sum_d      = 8'd0;
				position_d = POS_BODY;
			end
			default: begin
				push = accept;
				if (is_payload) begin
					sum_d      = sum_q + rx_byte;
					position_d = position_q + 8'd1;
				end else begin
					push_entry.is_end = 1'b1;
					position_d        = POS_HUNT;
				end
			end
		endcase
	end

	// State registers, updated on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= POS_HUNT;
			length_q   <= 8'd0;
			sum_q      <= 8'd0;
		end else if (accept) begin
			position_q <= position_d;
			length_q   <= length_d;
			sum_q      <= sum_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/hlcd_fifo.sv =====
// ----------------------------------------------------------------------------
// hlcd_fifo: event queue
// Small register queue between the frame tracker and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcd_fifo
	import hlcd_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire hlcd_entry_t  push_entry,
	input  wire logic         pop,
	output hlcd_entry_t       head_entry,
	output hlcd_fifo_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	hlcd_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign do_push      = push & ~status.full;
	assign do_pop       = pop & ~status.empty;
	assign head_entry   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/hlcd_back.sv =====
// ----------------------------------------------------------------------------
// hlcd_back: result stage
// Takes events from the queue, checks the frame checksum and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcd_back
	import hlcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hlcd_fifo_status_t fifo_status,
	input  wire hlcd_entry_t       head_entry,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             kind,
	output logic [7:0]             data_byte,
	output logic [7:0]             byte_position,
	output logic [7:0]             frame_length
);

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] data_q;
	logic [7:0] pos_q;
	logic [7:0] len_q;
	kind_t      kind_d;

	// Load when the output register is free or being drained
	assign pop = ~fifo_status.empty & (~out_valid_q | ~out_stall);

	// Checksum compare for end-of-frame events
	always_comb begin
		if (!head_entry.is_end) begin
			kind_d = KIND_PAYLOAD;
		end else if (head_entry.data == head_entry.csum) begin
			kind_d = KIND_GOOD;
		end else begin
			kind_d = KIND_BAD;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= kind_d;
			data_q <= head_entry.is_end ? 8'd0 : head_entry.data;
			pos_q  <= head_entry.pos;
			len_q  <= head_entry.len;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign data_byte     = data_q;
	assign byte_position = pos_q;
	assign frame_length  = len_q;

endmodule

`default_nettype wire

// ===== sv/header_length_checksum_deframer.sv =====
// ----------------------------------------------------------------------------
// header_length_checksum_deframer: two-byte-sync, length-prefixed frame receiver
// Hunts for two header bytes, reads the frame length, passes body bytes out
// and reports the additive checksum result at the end of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/rx_byte): one received byte per transfer.
//   Output channel (out_valid/out_stall/kind, data_byte, byte_position,
//   frame_length): one result per body byte; header and length bytes give none.
//   APB port: register 0 at 0x0 is sync_first, register 1 at 0x4 is
//   sync_second; write only while the block is idle.
//   Throughput: one byte per cycle while the queue has room, set by the
//   registered position/sum update in the frame tracker.
//   Path: a transferred byte is written into the queue, then moves into the
//   output register once that register is free or being drained; the
//   receiver can take it from there.
//   Reset: hunts for the first header, registers return to 0xAA and 0x55,
//   queue and output register empty.
//   Receiver stall: the output register holds its result, the queue fills,
//   and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_checksum_deframer
	import hlcd_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic [7:0]       byte_position,
	output logic [7:0]       frame_length,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0]        sync_first_q;
	logic [7:0]        sync_second_q;
	logic              cfg_wr;
	logic              push;
	logic              pop;
	hlcd_entry_t       push_entry;
	hlcd_entry_t       head_entry;
	hlcd_fifo_status_t fifo_status;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SYNC_FIRST) begin
				sync_first_q <= pwdata[7:0];
			end else begin
				sync_second_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = {24'd0, (paddr[2] == REG_SYNC_SECOND) ? sync_second_q : sync_first_q};

	hlcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.fifo_status (fifo_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	hlcd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.status     (fifo_status)
	);

	hlcd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_status   (fifo_status),
		.head_entry    (head_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.byte_position (byte_position),
		.frame_length  (frame_length)
	);

	// Checks
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_status.full)
		else $error("event pushed into a full queue");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_PAYLOAD || kind == KIND_GOOD || kind == KIND_BAD))
		else $error("undefined result kind");

	a_end_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_PAYLOAD) |-> data_byte == 8'd0)
		else $error("end-of-frame result carries data");

	a_payload_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_PAYLOAD) |->
		(byte_position >= POS_BODY && ({1'b0, byte_position} + 9'd1) < {1'b0, frame_length}))
		else $error("payload position outside frame body");

endmodule

`default_nettype wire

// ===== verif/tb_header_length_checksum_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_header_length_checksum_deframer: self-checking bench for the deframer
// Drives received bytes through a directed table and then random frames under
// several header settings. A behavioral frame tracker or the table predicts each result,
// and a scoreboard compares every output transfer field by field. Both sides
// idle at random, and the output side also holds off for a long stretch.
// ----------------------------------------------------------------------------

module tb_header_length_checksum_deframer
	import hlcd_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASE_BYTES   = 235;
	localparam int unsigned N_PHASES      = 6;
	localparam int unsigned N_ROWS        = 23;

	// how a directed row is checked
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_GIVEN
	} row_check_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] pos;
		logic [7:0] len;
	} frame_event_t;

	typedef struct packed {
		logic [7:0]   rx;
		row_check_t   chk;
		frame_event_t ev;
	} stim_row_t;

	// directed table: header hunt, short and normal frames, good and bad sums
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{8'h00, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'hAA, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		// wrong second header: the hunt restarts, this byte is dropped
		'{8'hAA, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h55, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'hAA, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h55, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h06, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'hFF, CHK_GIVEN, '{KIND_PAYLOAD, 8'hFF, 8'd3, 8'd6}},
		'{8'h01, CHK_GIVEN, '{KIND_PAYLOAD, 8'h01, 8'd4, 8'd6}},
		'{8'h00, CHK_GIVEN, '{KIND_GOOD,    8'h00, 8'd5, 8'd6}},
		// zero length: checksum at position 3, compared with zero
		'{8'hAA, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h55, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h00, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h00, CHK_GIVEN, '{KIND_GOOD,    8'h00, 8'd3, 8'd0}},
		// length four, no payload, bad checksum
		'{8'hAA, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h55, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h04, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'hFF, CHK_GIVEN, '{KIND_BAD,     8'h00, 8'd3, 8'd4}},
		// length five: one payload byte
		'{8'hAA, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h55, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h05, CHK_NONE,  '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h80, CHK_MODEL, '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}},
		'{8'h81, CHK_MODEL, '{KIND_PAYLOAD, 8'h00, 8'd0, 8'd0}}
	};

	// header settings per phase: reset values, extremes, equal, random, reset again
	logic [7:0] phase_first  [N_PHASES];
	logic [7:0] phase_second [N_PHASES];

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [7:0]  byte_position;
	logic [7:0]  frame_length;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// check mode and typed result of the byte on the input port
	row_check_t   drv_chk;
	frame_event_t drv_given;

	// frame tracker state and its copy of the header registers
	logic [7:0] trk_pos;
	logic [7:0] trk_len;
	logic [7:0] trk_sum;
	logic [7:0] hdr_first;
	logic [7:0] hdr_second;

	frame_event_t frame_events_due [$];
	int unsigned  error_count;
	int unsigned  cycle_count;
	bit           tx_quiet;
	bit           rx_quiet;
	bit           long_hold_req;

	header_length_checksum_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.byte_position (byte_position),
		.frame_length  (frame_length),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_header_length_checksum_deframer: FAIL");
			$finish;
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			error_count++;
		end
	endfunction

	// frame tracker: advance on one accepted byte, report any result it causes
	function automatic void track_rx_byte(input logic [7:0] b, output logic emit,
			output frame_event_t ev);
		emit = 1'b0;
		ev   = '0;
		if (trk_pos == POS_HUNT) begin
			if (b == hdr_first)
				trk_pos = POS_SYNC2;
		end else if (trk_pos == POS_SYNC2) begin
			trk_pos = (b == hdr_second) ? POS_LEN : POS_HUNT;
		end else if (trk_pos == POS_LEN) begin
			trk_len = b;
			trk_sum = 8'h00;
			trk_pos = POS_BODY;
		end else if (int'(trk_pos) < int'(trk_len) - 1) begin
			// payload byte, summed into the checksum
			emit    = 1'b1;
			ev      = '{KIND_PAYLOAD, b, trk_pos, trk_len};
			trk_sum = trk_sum + b;
			trk_pos = trk_pos + 8'd1;
		end else begin
			// checksum byte ends the frame
			emit    = 1'b1;
			ev      = '{(b == trk_sum) ? KIND_GOOD : KIND_BAD, 8'h00, trk_pos, trk_len};
			trk_pos = POS_HUNT;
		end
	endfunction

	// scoreboard: predict on input transfers, compare on output transfers
	always @(posedge clk) begin : scoreboard
		logic         emit;
		frame_event_t ev;
		frame_event_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				track_rx_byte(rx_byte, emit, ev);
				if (drv_chk == CHK_GIVEN)
					frame_events_due.push_back(drv_given);
				else if (drv_chk == CHK_MODEL && emit)
					frame_events_due.push_back(ev);
			end
			if (out_valid && !out_stall) begin
				if (frame_events_due.size() == 0) begin
					$error("unexpected result: kind %0d data 0x%02h pos %0d len %0d",
						kind, data_byte, byte_position, frame_length);
					error_count++;
				end else begin
					want = frame_events_due.pop_front();
					check_field("kind", {6'd0, want.kind}, {6'd0, kind});
					check_field("data_byte", want.data, data_byte);
					check_field("byte_position", want.pos, byte_position);
					check_field("frame_length", want.len, frame_length);
				end
			end
		end
	end

	// output side: random hold-off per transfer, quiet stretches, one long hold
	initial begin : receiver
		int unsigned hold;
		out_stall = 1'b0;
		rx_quiet  = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (rx_quiet) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 18);
			end
			if (hold != 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1 && !long_hold_req);
			@(negedge clk);
			if ($urandom_range(0, 15) == 0)
				rx_quiet = !rx_quiet;
		end
	end

	// one byte transfer; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input row_check_t chk,
			input frame_event_t given);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		rx_byte   = b;
		drv_chk   = chk;
		drv_given = given;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// one random frame; forced_len >= 0 gives a frame of that length, its checksum mostly correct
	task automatic send_frame(input int forced_len, output int unsigned count);
		logic [7:0]  frame_bytes [$];
		logic [7:0]  len;
		logic [7:0]  sum;
		logic [7:0]  b;
		int unsigned shape;
		shape = (forced_len >= 0) ? 99 : $urandom_range(0, 79);
		if (shape < 2) begin
			// line noise
			repeat ($urandom_range(1, 8))
				frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (shape < 4) begin
			// first header followed by a wrong second header
			frame_bytes.push_back(hdr_first);
			frame_bytes.push_back(hdr_second ^ 8'($urandom_range(1, 255)));
		end else begin
			if (forced_len >= 0)
				len = forced_len[7:0];
			else if (shape == 4)
				len = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(13, 254));
			else if (shape < 15)
				len = 8'($urandom_range(0, 4));
			else
				len = 8'($urandom_range(5, 12));
			if ($urandom_range(0, 5) == 0)
				frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes.push_back(hdr_first);
			frame_bytes.push_back(hdr_second);
			frame_bytes.push_back(len);
			sum = 8'h00;
			for (int i = 5; i <= int'(len); i++) begin
				b = 8'($urandom_range(0, 255));
				sum += b;
				frame_bytes.push_back(b);
			end
			// mostly a correct checksum, sometimes a random one
			frame_bytes.push_back(($urandom_range(0, 3) != 0) ? sum
				: 8'($urandom_range(0, 255)));
		end
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], CHK_MODEL, '0);
		count = frame_bytes.size();
	endtask

	// input side idle, every result in, then a settling wait for the pipeline
	task automatic drain();
		in_valid = 1'b0;
		while (frame_events_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [7:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {24'h0, value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (idx == REG_SYNC_FIRST)
			hdr_first = value;
		else
			hdr_second = value;
	endtask

	task automatic reg_check(input logic idx, input string name);
		logic [31:0] rd;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		check_field(name, (idx == REG_SYNC_FIRST) ? hdr_first : hdr_second, rd[7:0]);
	endtask

	// main sequence
	initial begin : stimulus
		int unsigned sent;
		int unsigned count;
		bit          paused;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		rx_byte       = 8'h00;
		drv_chk       = CHK_NONE;
		drv_given     = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		tx_quiet      = 1'b0;
		long_hold_req = 1'b0;
		error_count   = 0;
		paused        = 1'b0;
		trk_pos       = POS_HUNT;
		trk_len       = 8'h00;
		trk_sum       = 8'h00;
		hdr_first     = SYNC_FIRST_RST;
		hdr_second    = SYNC_SECOND_RST;
		phase_first   = '{SYNC_FIRST_RST, 8'h00, 8'hFF, 8'h5A, 8'($urandom_range(0, 255)),
			SYNC_FIRST_RST};
		phase_second  = '{SYNC_SECOND_RST, 8'hFF, 8'h00, 8'h5A, 8'($urandom_range(0, 255)),
			SYNC_SECOND_RST};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers come out of reset at their defaults
		reg_check(REG_SYNC_FIRST, "sync_first");
		reg_check(REG_SYNC_SECOND, "sync_second");

		// directed table
		for (int r = 0; r < N_ROWS; r++)
			send_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].chk, DIRECTED_ROWS[r].ev);
		drain();

		// random frames under each header setting
		for (int p = 0; p < N_PHASES; p++) begin
			if (p != 0) begin
				reg_write(REG_SYNC_FIRST, phase_first[p]);
				reg_write(REG_SYNC_SECOND, phase_second[p]);
				reg_check(REG_SYNC_FIRST, "sync_first");
				reg_check(REG_SYNC_SECOND, "sync_second");
			end
			// output side holds off while frames stream in back to back
			if (p == 2)
				long_hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				tx_quiet = (p == 2 && sent < 80) || ($urandom_range(0, 3) == 0);
				send_frame((p == 1 && sent == 0) ? 255 : -1, count);
				sent += count;
				// input pause mid-phase until the queue of results is empty
				if (p == 3 && !paused && sent > PHASE_BYTES / 2) begin
					drain();
					paused = 1'b1;
				end
			end
			tx_quiet = 1'b0;
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_header_length_checksum_deframer: PASS");
		else
			$display("tb_header_length_checksum_deframer: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/hlcd_pkg.sv
sv/hlcd_front.sv
sv/hlcd_fifo.sv
sv/hlcd_back.sv
sv/header_length_checksum_deframer.sv
verif/tb_header_length_checksum_deframer.sv
